// ===== hw/rtl/pfrs_pkg.sv =====
// Package: payload types and status codes for the per-flow receive statistics block
`timescale 1ns / 1ps
package pfrs_pkg;

   localparam logic [1:0] STATUS_COUNTED = 2'd0;
   localparam logic [1:0] STATUS_IGNORED = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   typedef struct packed {
      logic        source_is_ipv4;
      logic [31:0] source_address;
      logic [15:0] payload_bytes;
      logic [15:0] app_bytes;
      logic [31:0] sequence_number;
      logic [47:0] send_time_ns;
      logic [47:0] arrival_time_ns;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [5:0]         flow_slot;
      logic               new_flow;
      logic [63:0]        flow_payload_total;
      logic [63:0]        flow_app_total;
      logic [63:0]        flow_packet_total;
      logic [63:0]        flow_lost_total;
      logic signed [63:0] flow_delay_total_ns;
      logic [63:0]        flow_jitter_total_ns;
   } rsp_type;

   // classified word handed from the front end to the back end
   typedef struct packed {
      logic [1:0]         status;
      logic               fresh;
      logic [11:0]        slot;
      logic [15:0]        payload_bytes;
      logic [15:0]        app_bytes;
      logic [31:0]        sequence_number;
      logic signed [48:0] delay;
   } job_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_SEARCH,
      FE_PUSH
   } fe_state_type;

   typedef enum logic [2:0] {
      BE_IDLE,
      BE_READ,
      BE_CALC,
      BE_SUM,
      BE_OUT
   } be_state_type;

endpackage

// ===== hw/rtl/per_flow_rx_statistics.sv =====
// Top level: per-flow receive statistics, front end search and back end update
`timescale 1ns / 1ps
// Each packet word gives one result word. The front end searches the key
// table one slot a cycle through a registered read; the back end takes the
// job and then steps through counter read, jitter and gap, sum and the held
// result, while ignored and refused jobs go straight to the held result. One
// job register sits between them, so the front end may search the next word
// while the back end finishes. Non-IPv4 words and words refused on a full
// table pass straight through with zero totals. No clearing pass after reset.
module per_flow_rx_statistics #(
   parameter int FLOW_SLOTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pfrs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pfrs_pkg::rsp_type rsp_data
);

   localparam int SLOT_BITS = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;

   logic              job_valid, job_ready;
   pfrs_pkg::job_type job_data;

   pfrs_front #(.FLOW_SLOTS(FLOW_SLOTS), .SLOT_BITS(SLOT_BITS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .job_valid, .job_ready, .job_data
   );

   pfrs_back #(.FLOW_SLOTS(FLOW_SLOTS), .SLOT_BITS(SLOT_BITS)) u_back (
      .clock, .reset, .job_valid, .job_ready, .job_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

endmodule

// ===== hw/rtl/pfrs_front.sv =====
// Front end: accepts packet words, searches the key table, allocates slots
`timescale 1ns / 1ps
module pfrs_front #(
   parameter int FLOW_SLOTS = 64,
   parameter int SLOT_BITS  = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pfrs_pkg::req_type   req_data,
   output logic                job_valid,
   input  logic                job_ready,
   output pfrs_pkg::job_type   job_data
);

   localparam int CNT_BITS = SLOT_BITS + 1;

   pfrs_pkg::fe_state_type state_ff, state_in;
   pfrs_pkg::req_type      req_ff;
   logic [31:0]            key_mem [FLOW_SLOTS];
   logic [31:0]            key_rd_ff;
   logic [CNT_BITS-1:0]    alloc_ff;
   logic [CNT_BITS-1:0]    idx_ff, idx_in;
   logic                   rd_pend_ff;
   pfrs_pkg::job_type      job_ff, job_in;
   logic                   hit, exhausted, push_now;
   logic signed [48:0]     delay;

   assign delay = $signed({1'b0, req_ff.arrival_time_ns}) -
                  $signed({1'b0, req_ff.send_time_ns});
   // registered key read holds the slot just below the current index
   assign hit       = rd_pend_ff && (key_rd_ff == req_ff.source_address);
   assign exhausted = !hit && (idx_ff == alloc_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfrs_pkg::FE_IDLE:
            if (req_valid) state_in = req_data.source_is_ipv4 ?
                                      pfrs_pkg::FE_SEARCH : pfrs_pkg::FE_PUSH;
         pfrs_pkg::FE_SEARCH:
            if (hit || exhausted) state_in = pfrs_pkg::FE_PUSH;
         pfrs_pkg::FE_PUSH:
            if (job_ready) state_in = pfrs_pkg::FE_IDLE;
         default: state_in = pfrs_pkg::FE_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == pfrs_pkg::FE_IDLE);
      job_valid = (state_ff == pfrs_pkg::FE_PUSH);
      push_now  = (state_ff == pfrs_pkg::FE_SEARCH) && (hit || exhausted);
      idx_in    = idx_ff;
      job_in    = job_ff;
      if (state_ff == pfrs_pkg::FE_IDLE) idx_in = '0;
      else if (state_ff == pfrs_pkg::FE_SEARCH && !push_now && idx_ff != alloc_ff)
         idx_in = idx_ff + CNT_BITS'(1);
      if (state_ff == pfrs_pkg::FE_IDLE) begin
         job_in = '0;
         job_in.status = pfrs_pkg::STATUS_IGNORED;
      end else if (push_now) begin
         job_in.payload_bytes   = req_ff.payload_bytes;
         job_in.app_bytes       = req_ff.app_bytes;
         job_in.sequence_number = req_ff.sequence_number;
         job_in.delay           = delay;
         if (hit) begin
            job_in.status = pfrs_pkg::STATUS_COUNTED;
            job_in.fresh  = 1'b0;
            job_in.slot   = 12'(idx_ff - CNT_BITS'(1));
         end else if (alloc_ff == CNT_BITS'(FLOW_SLOTS)) begin
            job_in.status = pfrs_pkg::STATUS_FULL;
         end else begin
            job_in.status = pfrs_pkg::STATUS_COUNTED;
            job_in.fresh  = 1'b1;
            job_in.slot   = 12'(alloc_ff);
         end
      end
   end

   assign job_data = job_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= pfrs_pkg::FE_IDLE;
         alloc_ff   <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= (state_ff == pfrs_pkg::FE_SEARCH) && !push_now &&
                       (idx_ff != alloc_ff);
         if (push_now && !hit && alloc_ff != CNT_BITS'(FLOW_SLOTS))
            alloc_ff <= alloc_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      job_ff <= job_in;
      if (req_valid && req_ready) req_ff <= req_data;
      if (state_ff == pfrs_pkg::FE_SEARCH && idx_ff != alloc_ff)
         key_rd_ff <= key_mem[idx_ff[SLOT_BITS-1:0]];
      if (push_now && !hit && alloc_ff != CNT_BITS'(FLOW_SLOTS))
         key_mem[alloc_ff[SLOT_BITS-1:0]] <= req_ff.source_address;
   end

endmodule

// ===== hw/rtl/pfrs_back.sv =====
// Back end: per-slot counter read-modify-write and result register
`timescale 1ns / 1ps
module pfrs_back #(
   parameter int FLOW_SLOTS = 64,
   parameter int SLOT_BITS  = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  pfrs_pkg::job_type job_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pfrs_pkg::rsp_type rsp_data
);

   pfrs_pkg::be_state_type state_ff, state_in;
   pfrs_pkg::job_type      job_ff;
   logic [63:0]            pay_mem [FLOW_SLOTS];
   logic [63:0]            app_mem [FLOW_SLOTS];
   logic [63:0]            pkt_mem [FLOW_SLOTS];
   logic [63:0]            lost_mem [FLOW_SLOTS];
   logic [63:0]            dly_mem [FLOW_SLOTS];
   logic [63:0]            jit_mem [FLOW_SLOTS];
   logic [48:0]            prev_mem [FLOW_SLOTS];
   logic [31:0]            exp_mem [FLOW_SLOTS];
   logic [63:0]            pay_ff, app_ff, pkt_ff, lost_ff, dly_ff, jit_ff;
   logic [48:0]            prev_ff;
   logic [31:0]            exp_ff;
   logic [63:0]            gap_ff, diff_ff;
   logic signed [49:0]     d;
   logic [SLOT_BITS-1:0]   slot;
   pfrs_pkg::rsp_type      rsp_ff;
   pfrs_pkg::rsp_type      rsp_clr;

   assign slot = job_ff.slot[SLOT_BITS-1:0];
   assign d    = 50'(job_ff.delay) - 50'($signed(prev_ff));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfrs_pkg::BE_IDLE:
            if (job_valid) state_in = (job_data.status == pfrs_pkg::STATUS_COUNTED) ?
                                      pfrs_pkg::BE_READ : pfrs_pkg::BE_OUT;
         pfrs_pkg::BE_READ: state_in = pfrs_pkg::BE_CALC;
         pfrs_pkg::BE_CALC: state_in = pfrs_pkg::BE_SUM;
         pfrs_pkg::BE_SUM:  state_in = pfrs_pkg::BE_OUT;
         pfrs_pkg::BE_OUT:  if (rsp_ready) state_in = pfrs_pkg::BE_IDLE;
         default: state_in = pfrs_pkg::BE_IDLE;
      endcase
   end

   always_comb begin
      job_ready = (state_ff == pfrs_pkg::BE_IDLE);
      rsp_valid = (state_ff == pfrs_pkg::BE_OUT);
   end

   // result word starts from zero totals with the job's status
   always_comb begin
      rsp_clr        = '0;
      rsp_clr.status = job_data.status;
   end

   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= pfrs_pkg::BE_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (job_valid && job_ready) begin
         job_ff <= job_data;
         rsp_ff <= rsp_clr;
      end
      if (state_ff == pfrs_pkg::BE_READ) begin
         pay_ff  <= pay_mem[slot];
         app_ff  <= app_mem[slot];
         pkt_ff  <= pkt_mem[slot];
         lost_ff <= lost_mem[slot];
         dly_ff  <= dly_mem[slot];
         jit_ff  <= jit_mem[slot];
         prev_ff <= prev_mem[slot];
         exp_ff  <= exp_mem[slot];
      end
      if (state_ff == pfrs_pkg::BE_CALC) begin
         // new flow restarts every counter and adds no jitter or loss
         diff_ff <= job_ff.fresh ? 64'd0 : 64'(d < 0 ? -d : d);
         gap_ff  <= (!job_ff.fresh && job_ff.sequence_number > exp_ff) ?
                    64'(job_ff.sequence_number - exp_ff) : 64'd0;
         if (job_ff.fresh) begin
            pay_ff <= '0; app_ff <= '0; pkt_ff <= '0;
            lost_ff <= '0; dly_ff <= '0; jit_ff <= '0;
         end
      end
      if (state_ff == pfrs_pkg::BE_SUM) begin
         rsp_ff.flow_slot            <= 6'(slot);
         rsp_ff.new_flow             <= job_ff.fresh;
         rsp_ff.flow_payload_total   <= pay_ff + 64'(job_ff.payload_bytes);
         rsp_ff.flow_app_total       <= app_ff + 64'(job_ff.app_bytes);
         rsp_ff.flow_packet_total    <= pkt_ff + 64'd1;
         rsp_ff.flow_lost_total      <= lost_ff + gap_ff;
         rsp_ff.flow_delay_total_ns  <= dly_ff + 64'(job_ff.delay);
         rsp_ff.flow_jitter_total_ns <= jit_ff + diff_ff;
         pay_mem[slot]  <= pay_ff + 64'(job_ff.payload_bytes);
         app_mem[slot]  <= app_ff + 64'(job_ff.app_bytes);
         pkt_mem[slot]  <= pkt_ff + 64'd1;
         lost_mem[slot] <= lost_ff + gap_ff;
         dly_mem[slot]  <= dly_ff + 64'(job_ff.delay);
         jit_mem[slot]  <= jit_ff + diff_ff;
         prev_mem[slot] <= job_ff.delay;
         exp_mem[slot]  <= job_ff.sequence_number + 32'd1;
      end
   end

endmodule

// ===== hw/rtl/pfrs_checker.sv =====
// Port checker for the per-flow receive statistics block, with its bind
`timescale 1ns / 1ps
module pfrs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input pfrs_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status == pfrs_pkg::STATUS_COUNTED ||
                    rsp_data.status == pfrs_pkg::STATUS_IGNORED ||
                    rsp_data.status == pfrs_pkg::STATUS_FULL)
      else $error("bad status code");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != pfrs_pkg::STATUS_COUNTED |->
      rsp_data.flow_packet_total == 64'd0 && !rsp_data.new_flow)
      else $error("dropped word carries totals");

   a_fresh_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.new_flow |-> rsp_data.flow_packet_total == 64'd1 &&
      rsp_data.flow_lost_total == 64'd0 && rsp_data.flow_jitter_total_ns == 64'd0)
      else $error("new flow does not start from zero");

   // one word at a time in the front end
   a_req_single: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while a word is in the front end");

endmodule

bind per_flow_rx_statistics pfrs_checker u_pfrs_checker (.*);

// ===== tb/tb.sv =====
// Testbench for the per-flow receive statistics block: predicted flow counters checked per word
`timescale 1ns / 1ps
module tb;

   localparam int SLOTS = 64;
   localparam int RANDOM_WORDS = 700;
   localparam longint CYCLE_LIMIT = 2000000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   pfrs_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   pfrs_pkg::rsp_type rsp_data;

   bit     failed = 1'b0;
   longint cycles = 0;
   bit     sending_done = 1'b0;

   per_flow_rx_statistics dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   class flow_scoreboard;
      bit          used [SLOTS];
      logic [31:0] key [SLOTS];
      logic [63:0] pay_sum [SLOTS], app_sum [SLOTS], pkt_sum [SLOTS], lost_sum [SLOTS];
      logic [63:0] delay_sum [SLOTS], jitter_sum [SLOTS];
      logic signed [48:0] last_delay [SLOTS];
      logic [31:0] next_seq [SLOTS];
      int          allocated;
      pfrs_pkg::rsp_type pending [$];

      function void note_packet(pfrs_pkg::req_type r);
         pfrs_pkg::rsp_type e;
         int s;
         bit hit;
         logic signed [48:0] d;
         logic signed [49:0] diff;
         e = '0;
         hit = 1'b0;
         s = 0;
         if (!r.source_is_ipv4) begin
            e.status = pfrs_pkg::STATUS_IGNORED;
            pending = {pending, e};
            return;
         end
         for (int i = 0; i < allocated; i++)
            if (!hit && used[i] && key[i] == r.source_address) begin
               hit = 1'b1;
               s = i;
            end
         if (!hit) begin
            if (allocated >= SLOTS) begin
               e.status = pfrs_pkg::STATUS_FULL;
               pending = {pending, e};
               return;
            end
            s = allocated;
            allocated++;
            used[s] = 1'b1;
            key[s] = r.source_address;
            pay_sum[s] = 0; app_sum[s] = 0; pkt_sum[s] = 0;
            lost_sum[s] = 0; delay_sum[s] = 0; jitter_sum[s] = 0;
         end
         d = $signed({1'b0, r.arrival_time_ns}) - $signed({1'b0, r.send_time_ns});
         pay_sum[s] += 64'(r.payload_bytes);
         app_sum[s] += 64'(r.app_bytes);
         pkt_sum[s] += 64'd1;
         delay_sum[s] += 64'(d);
         if (hit) begin
            diff = 50'(d) - 50'(last_delay[s]);
            jitter_sum[s] += (diff < 0) ? 64'(-diff) : 64'(diff);
            if (r.sequence_number > next_seq[s])
               lost_sum[s] += 64'(r.sequence_number - next_seq[s]);
         end
         last_delay[s] = d;
         next_seq[s] = r.sequence_number + 32'd1;
         e.status = pfrs_pkg::STATUS_COUNTED;
         e.flow_slot = s[5:0];
         e.new_flow = !hit;
         e.flow_payload_total = pay_sum[s];
         e.flow_app_total = app_sum[s];
         e.flow_packet_total = pkt_sum[s];
         e.flow_lost_total = lost_sum[s];
         e.flow_delay_total_ns = delay_sum[s];
         e.flow_jitter_total_ns = jitter_sum[s];
         pending = {pending, e};
      endfunction

      function bit check_result(pfrs_pkg::rsp_type a);
         pfrs_pkg::rsp_type e;
         bit ok;
         ok = 1'b1;
         if (pending.size() == 0) begin
            $error("result word with nothing expected");
            return 1'b0;
         end
         e = pending.pop_front();
         if (a.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, a.status); ok = 0; end
         if (a.flow_slot !== e.flow_slot) begin
            $error("flow_slot exp %0d got %0d", e.flow_slot, a.flow_slot); ok = 0; end
         if (a.new_flow !== e.new_flow) begin
            $error("new_flow exp %0d got %0d", e.new_flow, a.new_flow); ok = 0; end
         if (a.flow_payload_total !== e.flow_payload_total) begin
            $error("flow_payload_total exp %0h got %0h",
                   e.flow_payload_total, a.flow_payload_total); ok = 0; end
         if (a.flow_app_total !== e.flow_app_total) begin
            $error("flow_app_total exp %0h got %0h",
                   e.flow_app_total, a.flow_app_total); ok = 0; end
         if (a.flow_packet_total !== e.flow_packet_total) begin
            $error("flow_packet_total exp %0h got %0h",
                   e.flow_packet_total, a.flow_packet_total); ok = 0; end
         if (a.flow_lost_total !== e.flow_lost_total) begin
            $error("flow_lost_total exp %0h got %0h",
                   e.flow_lost_total, a.flow_lost_total); ok = 0; end
         if (a.flow_delay_total_ns !== e.flow_delay_total_ns) begin
            $error("flow_delay_total_ns exp %0h got %0h",
                   e.flow_delay_total_ns, a.flow_delay_total_ns); ok = 0; end
         if (a.flow_jitter_total_ns !== e.flow_jitter_total_ns) begin
            $error("flow_jitter_total_ns exp %0h got %0h",
                   e.flow_jitter_total_ns, a.flow_jitter_total_ns); ok = 0; end
         return ok;
      endfunction
   endclass

   flow_scoreboard board = new();

   // address pool kept small so flows recur; a few beyond 64 fill the table
   logic [31:0] addr_pool [80];
   logic [31:0] seq_track [80];

   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // valid stays up between back-to-back words and drops only for a gap or a drain
   task automatic send_word(pfrs_pkg::req_type w);
      int g;
      g = gap_cycles();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_packet(w);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   function automatic pfrs_pkg::req_type random_word(int pool_size);
      pfrs_pkg::req_type w;
      int k;
      logic [47:0] base;
      w = '0;
      w.source_is_ipv4 = ($urandom_range(0, 19) != 0);
      k = $urandom_range(0, pool_size - 1);
      w.source_address = ($urandom_range(0, 29) == 0) ? $urandom() : addr_pool[k];
      w.payload_bytes = 16'($urandom());
      w.app_bytes = 16'($urandom());
      case ($urandom_range(0, 5))
         0: seq_track[k] = $urandom();
         1: seq_track[k] = seq_track[k] - $urandom_range(0, 5);
         2: seq_track[k] = seq_track[k] + $urandom_range(2, 1000);
         default: seq_track[k] = seq_track[k] + 1;
      endcase
      w.sequence_number = seq_track[k];
      base = {$urandom(), 16'($urandom())};
      if ($urandom_range(0, 9) == 0) begin
         w.send_time_ns = base;
         w.arrival_time_ns = {$urandom(), 16'($urandom())};
      end else begin
         w.send_time_ns = base;
         w.arrival_time_ns = base + 48'($urandom_range(0, 2000000));
      end
      return w;
   endfunction

   initial begin
      pfrs_pkg::req_type w;
      for (int i = 0; i < 80; i++) begin
         addr_pool[i] = $urandom();
         seq_track[i] = $urandom();
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: ignored word, extremes, negative delay, backward sequence
      w = '0;
      send_word(w);
      w = '1;
      send_word(w);
      w.sequence_number = 32'hffff_ffff;
      send_word(w);
      w.sequence_number = 32'd5;
      send_word(w);
      w = '0;
      w.source_is_ipv4 = 1'b1;
      w.send_time_ns = 48'hffff_ffff_ffff;
      send_word(w);
      w.sequence_number = 32'd10;
      w.arrival_time_ns = 48'hffff_ffff_ffff;
      w.send_time_ns = 48'd0;
      w.payload_bytes = 16'hffff;
      send_word(w);
      w.sequence_number = 32'd10;
      send_word(w);
      w.sequence_number = 32'd3;
      send_word(w);
      w.source_is_ipv4 = 1'b0;
      w.source_address = 32'h5555_aaaa;
      send_word(w);

      wait_drained();

      // fill past capacity: first 40 pool entries, then all 80, plus the above two flows
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         w = random_word((i < 200) ? 40 : 80);
         send_word(w);
         if (i == 350) wait_drained();
      end
      // table full case for certain
      for (int i = 0; i < 70; i++) begin
         w = random_word(80);
         w.source_is_ipv4 = 1'b1;
         w.source_address = addr_pool[i];
         send_word(w);
      end
      req_valid <= 1'b0;
      sending_done = 1'b1;
   end

   // result side with random stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            if (!board.check_result(rsp_data)) failed = 1'b1;
         if ($urandom_range(0, 9) < 7) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 19) == 0) ? 1'b1 : 1'b0;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      wait (sending_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (!failed && board.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
